// ===== rtl/wpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_pkg
// Shared widths, codes and types of the white-patch white balance block.
// ----------------------------------------------------------------------------
package wpb_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int GAIN_FRAC_BITS = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_BLUE  = 2'd2;

  // pixel commands
  localparam logic CMD_GATHER = 1'b0;
  localparam logic CMD_APPLY  = 1'b1;

  localparam logic [PIX_W-1:0] WHITE_RESET = 8'd255;

  // per-transaction strobes handed to every channel lane
  typedef struct packed {
    logic gather;
    logic apply;
    logic last;
  } lane_ctrl_t;

endpackage

// ===== rtl/wpb_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb interfaces
// Pixel input, balanced result and configuration write channels.
// ----------------------------------------------------------------------------
interface wpb_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [wpb_pkg::PIX_W-1:0] pix_red;
  logic [wpb_pkg::PIX_W-1:0] pix_green;
  logic [wpb_pkg::PIX_W-1:0] pix_blue;
  logic                     last_pixel;

  modport source (output valid, cmd, pix_red, pix_green, pix_blue, last_pixel,
                  input ready);
  modport sink   (input valid, cmd, pix_red, pix_green, pix_blue, last_pixel,
                  output ready);
endinterface

interface wpb_res_if;
  logic                     valid;
  logic                     ready;
  logic [wpb_pkg::PIX_W-1:0] out_red;
  logic [wpb_pkg::PIX_W-1:0] out_green;
  logic [wpb_pkg::PIX_W-1:0] out_blue;
  logic                     out_last;

  modport source (output valid, out_red, out_green, out_blue, out_last,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_last,
                  output ready);
endinterface

interface wpb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wpb_pkg::CFG_IDX_W-1:0] index;
  logic [wpb_pkg::PIX_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/white_patch_balance.sv =====
`timescale 1ns / 1ps
// Gather pixel: one per cycle; the last gather pixel holds the input off while
//   the lanes divide, one quotient bit a cycle.
// Apply pixel: the product register, then the saturating output register once it
//   has room; the input is held off until the products are handed on.
// Reset (rst, synchronous): targets return to 255, peaks and gains to 0,
//   the output register empties.
// ----------------------------------------------------------------------------
// white_patch_balance
// Per-channel white-patch balance over a twice-presented RGB frame.
// ----------------------------------------------------------------------------
module white_patch_balance #(
  parameter int GAIN_FRACTION_BITS = wpb_pkg::GAIN_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  wpb_pix_if.sink   pix,
  wpb_res_if.source res,
  wpb_cfg_if.sink   cfg
);

  localparam int PROD_W = 2 * wpb_pkg::PIX_W + GAIN_FRACTION_BITS;

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;  // take the next pixel
  localparam logic [1:0] S_DIV  = 2'd1;  // lanes work out fresh gains
  localparam logic [1:0] S_MUL  = 2'd2;  // products ready, wait for output slot

  logic [1:0] state;
  logic [1:0] state_next;

  logic [wpb_pkg::PIX_W-1:0] white_red;
  logic [wpb_pkg::PIX_W-1:0] white_green;
  logic [wpb_pkg::PIX_W-1:0] white_blue;

  logic                pix_take;
  wpb_pkg::lane_ctrl_t ctrl;
  logic                busy_red;
  logic                busy_green;
  logic                busy_blue;
  logic [PROD_W-1:0]   prod_red;
  logic [PROD_W-1:0]   prod_green;
  logic [PROD_W-1:0]   prod_blue;
  logic                last;
  logic                free;
  logic                load;

  // Configuration: always ready; an unknown index is dropped. The user must let writes
  // arrive only while idle so gain divisions see stable targets; not enforced by the block.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_red   <= wpb_pkg::WHITE_RESET;
      white_green <= wpb_pkg::WHITE_RESET;
      white_blue  <= wpb_pkg::WHITE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        wpb_pkg::REG_WHITE_RED:   white_red   <= cfg.data;
        wpb_pkg::REG_WHITE_GREEN: white_green <= cfg.data;
        wpb_pkg::REG_WHITE_BLUE:  white_blue  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pixel intake: one transaction at a time through the idle state.
  assign pix.ready = (state == S_IDLE);
  assign pix_take  = pix.valid && pix.ready;

  always_comb begin
    ctrl.gather = pix_take && (pix.cmd == wpb_pkg::CMD_GATHER);
    ctrl.apply  = pix_take && (pix.cmd == wpb_pkg::CMD_APPLY);
    ctrl.last   = pix.last_pixel;
  end

  // Hand the products to the output register once it has room.
  assign load = (state == S_MUL) && free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctrl.apply) begin
          state_next = S_MUL;
        end else if (ctrl.gather && ctrl.last) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!(busy_red || busy_green || busy_blue)) begin
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        if (free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the frame-end flag of the apply pixel alongside its products.
  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      last <= pix.last_pixel;
    end
  end

  // Three lanes, one per colour channel, run in lock step.
  wpb_lane #(.FRAC(GAIN_FRACTION_BITS)) u_lane_red (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .pix   (pix.pix_red),
    .white (white_red),
    .busy  (busy_red),
    .prod  (prod_red)
  );

  wpb_lane #(.FRAC(GAIN_FRACTION_BITS)) u_lane_green (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .pix   (pix.pix_green),
    .white (white_green),
    .busy  (busy_green),
    .prod  (prod_green)
  );

  wpb_lane #(.FRAC(GAIN_FRACTION_BITS)) u_lane_blue (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .pix   (pix.pix_blue),
    .white (white_blue),
    .busy  (busy_blue),
    .prod  (prod_blue)
  );

  // Saturate and register the combined result.
  wpb_merge #(.FRAC(GAIN_FRACTION_BITS)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .last       (last),
    .prod_red   (prod_red),
    .prod_green (prod_green),
    .prod_blue  (prod_blue),
    .free       (free),
    .res        (res)
  );

endmodule

// ===== rtl/wpb_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_lane
// One colour channel: running peak, bit-serial gain divider, gain multiply.
// ----------------------------------------------------------------------------
module wpb_lane #(
  parameter int FRAC = wpb_pkg::GAIN_FRAC_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  wpb_pkg::lane_ctrl_t                         ctrl,
  input  logic [wpb_pkg::PIX_W-1:0]                   pix,
  input  logic [wpb_pkg::PIX_W-1:0]                   white,
  output logic                                        busy,
  output logic [2*wpb_pkg::PIX_W+FRAC-1:0]            prod
);

  localparam int GAIN_W = wpb_pkg::PIX_W + FRAC;
  localparam int PROD_W = wpb_pkg::PIX_W + GAIN_W;
  localparam int CNT_W  = $clog2(GAIN_W + 1);

  logic [wpb_pkg::PIX_W-1:0] peak;
  logic [wpb_pkg::PIX_W-1:0] peak_next;
  logic [wpb_pkg::PIX_W-1:0] divisor;
  logic [wpb_pkg::PIX_W-1:0] rem;
  logic [GAIN_W-1:0]         quo;
  logic [GAIN_W-1:0]         quo_next;
  logic [GAIN_W-1:0]         gain;
  logic [CNT_W-1:0]          cnt;
  logic                      zero_peak;
  logic [wpb_pkg::PIX_W:0]   rem_sh;
  logic [wpb_pkg::PIX_W:0]   rem_diff;
  logic                      fits;
  logic [wpb_pkg::PIX_W-1:0] rem_next;

  assign peak_next = (pix > peak) ? pix : peak;

  // one quotient bit per cycle while busy
  always_comb begin
    rem_sh   = {rem, quo[GAIN_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    fits     = (rem_sh >= {1'b0, divisor});
    rem_next = fits ? rem_diff[wpb_pkg::PIX_W-1:0] : rem_sh[wpb_pkg::PIX_W-1:0];
    quo_next = {quo[GAIN_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
      gain <= '0;
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (ctrl.gather) begin
        if (ctrl.last) begin
          peak <= '0;
          busy <= 1'b1;
          cnt  <= CNT_W'(GAIN_W);
        end else begin
          peak <= peak_next;
        end
      end
      if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          gain <= zero_peak ? '0 : quo_next;
        end
      end
    end
  end

  // divider datapath and product register
  always_ff @(posedge clk) begin
    if (ctrl.gather && ctrl.last) begin
      divisor   <= peak_next;
      zero_peak <= (peak_next == '0);
      rem       <= '0;
      quo       <= {white, {FRAC{1'b0}}};
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (ctrl.apply) begin
      prod <= PROD_W'(pix) * PROD_W'(gain);
    end
  end

endmodule

// ===== rtl/wpb_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_merge
// Combine the lane products into one saturated, registered result.
// ----------------------------------------------------------------------------
module wpb_merge #(
  parameter int FRAC = wpb_pkg::GAIN_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic                             last,
  input  logic [2*wpb_pkg::PIX_W+FRAC-1:0] prod_red,
  input  logic [2*wpb_pkg::PIX_W+FRAC-1:0] prod_green,
  input  logic [2*wpb_pkg::PIX_W+FRAC-1:0] prod_blue,
  output logic                             free,
  wpb_res_if.source                        res
);

  localparam int PW    = wpb_pkg::PIX_W;
  localparam int PROD_W = 2 * PW + FRAC;

  logic [PW-1:0] sat_red;
  logic [PW-1:0] sat_green;
  logic [PW-1:0] sat_blue;

  // saturate at full scale when any bit above the integer byte is set
  always_comb begin
    sat_red   = (|prod_red[PROD_W-1:FRAC+PW])   ? '1 : prod_red[FRAC+PW-1:FRAC];
    sat_green = (|prod_green[PROD_W-1:FRAC+PW]) ? '1 : prod_green[FRAC+PW-1:FRAC];
    sat_blue  = (|prod_blue[PROD_W-1:FRAC+PW])  ? '1 : prod_blue[FRAC+PW-1:FRAC];
  end

  assign free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.out_red   <= sat_red;
      res.out_green <= sat_green;
      res.out_blue  <= sat_blue;
      res.out_last  <= last;
    end
  end

endmodule

// ===== rtl/wpb_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_check
// Port-level checks of the white balance block, bound to the top level.
// ----------------------------------------------------------------------------
module wpb_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      pix_valid,
  input logic                      pix_ready,
  input logic                      pix_cmd,
  input logic                      pix_last,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [wpb_pkg::PIX_W-1:0] res_red,
  input logic [wpb_pkg::PIX_W-1:0] res_green,
  input logic [wpb_pkg::PIX_W-1:0] res_blue,
  input logic                      res_last
);

  logic       apply_take;
  logic       res_take;
  logic [1:0] pending;

  assign apply_take = pix_valid && pix_ready && (pix_cmd == wpb_pkg::CMD_APPLY);
  assign res_take   = res_valid && res_ready;

  // apply transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, apply_take} - {1'b0, res_take};
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_red) && $stable(res_green)
      && $stable(res_blue) && $stable(res_last))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 2'd0 && pending != 2'd3)
    else $error("result without an apply pixel");

  a_gain_busy: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && pix_cmd == wpb_pkg::CMD_GATHER && pix_last |=> !pix_ready)
    else $error("pixel taken while gains are being computed");

  a_apply_gap: assert property (@(posedge clk) disable iff (rst)
    apply_take |=> !pix_ready)
    else $error("pixel taken while products wait");

endmodule

bind white_patch_balance wpb_check u_wpb_check (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pix_cmd   (pix.cmd),
  .pix_last  (pix.last_pixel),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_red   (res.out_red),
  .res_green (res.out_green),
  .res_blue  (res.out_blue),
  .res_last  (res.out_last)
);
